FILE: hw/rtl/lpfr_pkg.sv
package lpfr_pkg;

    // Field widths.
    localparam int CMD_W   = 2;
    localparam int BYTE_W  = 8;
    localparam int MS_W    = 45;
    localparam int KIND_W  = 2;
    localparam int WORD_W  = 32;
    localparam int HALF_W  = 16;
    localparam int CIDX_W  = 3;
    localparam int HIDX_W  = 5;
    localparam int TS_W    = 64;

    // Header geometry and fixed values.
    localparam int HDR_BYTES = 32;
    localparam logic [HIDX_W-1:0] HDR_LAST_IDX = HIDX_W'(HDR_BYTES - 1);
    localparam logic [WORD_W-1:0] HDR_MAGIC = 32'h5852_4346;
    localparam logic [19:0] NS_PER_MS = 20'd1000000;

    // Input commands.
    localparam logic [CMD_W-1:0] CMD_DATA  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_OPEN  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLOSE = 2'd2;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_HEADER  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BAD_LEN = 2'd2;
    localparam logic [KIND_W-1:0] KIND_ABORT   = 2'd3;

    // Configuration register indexes.
    localparam logic [CIDX_W-1:0] REG_MAX_LEN = 3'd0;
    localparam logic [CIDX_W-1:0] REG_VERSION = 3'd1;
    localparam logic [CIDX_W-1:0] REG_CODEC   = 3'd2;
    localparam logic [CIDX_W-1:0] REG_WIDTH   = 3'd3;
    localparam logic [CIDX_W-1:0] REG_HEIGHT  = 3'd4;

    // Configuration reset values.
    localparam logic [WORD_W-1:0] RST_MAX_LEN = 32'd8388608;
    localparam logic [HALF_W-1:0] RST_VERSION = 16'd1;
    localparam logic [HALF_W-1:0] RST_CODEC   = 16'd1;
    localparam logic [WORD_W-1:0] RST_WIDTH   = 32'd1280;
    localparam logic [WORD_W-1:0] RST_HEIGHT  = 32'd480;

    // Parser phase.
    typedef enum logic [1:0] {
        PH_PREFIX  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_HALTED  = 2'd2
    } t_phase;

    // Configuration values seen by the datapath.
    typedef struct packed {
        logic [WORD_W-1:0] max_len;
        logic [HALF_W-1:0] version;
        logic [HALF_W-1:0] codec;
        logic [WORD_W-1:0] width;
        logic [WORD_W-1:0] height;
    } t_cfg;

    // Result request from parser to emitter.
    typedef struct packed {
        logic              valid;
        logic              hdr;
        logic [BYTE_W-1:0] data;
        logic [KIND_W-1:0] kind;
        logic              fend;
        logic [WORD_W-1:0] len;
        logic [WORD_W-1:0] seq;
        logic [MS_W-1:0]   ms;
    } t_req;

endpackage

FILE: hw/rtl/lpfr_ifs.sv
interface lpfr_in_if import lpfr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [BYTE_W-1:0] in_byte;
    logic [MS_W-1:0]   time_ms;

    modport source (output valid, output cmd, output in_byte, output time_ms, input ready);
    modport sink   (input valid, input cmd, input in_byte, input time_ms, output ready);
endinterface

interface lpfr_out_if import lpfr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic [KIND_W-1:0] kind;
    logic              frame_end;
    logic              run_last;

    modport source (output valid, output out_byte, output kind, output frame_end,
                    output run_last, input ready);
    modport sink   (input valid, input out_byte, input kind, input frame_end,
                    input run_last, output ready);
endinterface

interface lpfr_cfg_if import lpfr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CIDX_W-1:0] index;
    logic [WORD_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/lpfr_regs.sv
module lpfr_regs import lpfr_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    lpfr_cfg_if.sink       i_cfg,
    output t_cfg           o_cfg
);

    t_cfg r_cfg;

    // Writes are always taken; unknown indexes are dropped.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_len <= RST_MAX_LEN;
            r_cfg.version <= RST_VERSION;
            r_cfg.codec   <= RST_CODEC;
            r_cfg.width   <= RST_WIDTH;
            r_cfg.height  <= RST_HEIGHT;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_MAX_LEN: r_cfg.max_len <= i_cfg.data;
                REG_VERSION: r_cfg.version <= i_cfg.data[HALF_W-1:0];
                REG_CODEC:   r_cfg.codec   <= i_cfg.data[HALF_W-1:0];
                REG_WIDTH:   r_cfg.width   <= i_cfg.data;
                REG_HEIGHT:  r_cfg.height  <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: hw/rtl/lpfr_parser.sv
module lpfr_parser import lpfr_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    lpfr_in_if.sink        i_in,
    input  t_cfg           i_cfg,
    input  logic           i_res_free,
    output t_req           o_req
);

    // Input register.
    logic              r_in_valid;
    logic [CMD_W-1:0]  r_cmd;
    logic [BYTE_W-1:0] r_byte;
    logic [MS_W-1:0]   r_ms;

    // Parser state.
    t_phase            r_phase, n_phase;
    logic [1:0]        r_cnt, n_cnt;
    logic [WORD_W-1:0] r_acc, n_acc;
    logic [WORD_W-1:0] r_rem, n_rem;
    logic [WORD_W-1:0] r_seq, n_seq;

    logic              adv;
    logic [WORD_W-1:0] acc_next;
    logic [WORD_W-1:0] rem_dec;
    t_req              req;

    // The held word moves on once the emitter can take its results.
    assign adv        = r_in_valid && i_res_free;
    assign i_in.ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_cmd  <= i_in.cmd;
            r_byte <= i_in.in_byte;
            r_ms   <= i_in.time_ms;
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PREFIX;
            r_cnt   <= 2'd0;
            r_acc   <= '0;
            r_rem   <= '0;
            r_seq   <= '0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_acc   <= n_acc;
            r_rem   <= n_rem;
            r_seq   <= n_seq;
        end
    end

    assign acc_next = {r_acc[WORD_W-BYTE_W-1:0], r_byte};
    assign rem_dec  = (r_rem != '0) ? r_rem - WORD_W'(1) : r_rem;

    // Next state and the result request for the held word.
    always_comb begin
        n_phase  = r_phase;
        n_cnt    = r_cnt;
        n_acc    = r_acc;
        n_rem    = r_rem;
        n_seq    = r_seq;
        req      = '0;
        req.len  = acc_next;
        req.ms   = r_ms;
        req.data = r_byte;
        if (adv) begin
            case (r_cmd)
                CMD_OPEN: begin
                    n_phase = PH_PREFIX;
                    n_cnt   = 2'd0;
                    n_acc   = '0;
                    n_rem   = '0;
                end
                CMD_CLOSE: begin
                    n_phase = PH_HALTED;
                    n_cnt   = 2'd0;
                    n_acc   = '0;
                    n_rem   = '0;
                    if (r_phase == PH_PAYLOAD) begin
                        req.valid = 1'b1;
                        req.kind  = KIND_ABORT;
                        req.data  = '0;
                    end
                end
                CMD_DATA: begin
                    case (r_phase)
                        PH_PREFIX: begin
                            n_cnt = r_cnt + 2'd1;
                            n_acc = acc_next;
                            if (r_cnt == 2'd3) begin
                                n_acc     = '0;
                                req.valid = 1'b1;
                                if (acc_next == '0 || acc_next > i_cfg.max_len) begin
                                    n_phase  = PH_HALTED;
                                    req.kind = KIND_BAD_LEN;
                                    req.data = '0;
                                end else begin
                                    n_seq    = r_seq + WORD_W'(1);
                                    n_rem    = acc_next;
                                    n_phase  = PH_PAYLOAD;
                                    req.hdr  = 1'b1;
                                    req.kind = KIND_HEADER;
                                    req.seq  = n_seq;
                                end
                            end
                        end
                        PH_PAYLOAD: begin
                            n_rem     = rem_dec;
                            req.valid = 1'b1;
                            req.kind  = KIND_PAYLOAD;
                            req.fend  = (rem_dec == '0);
                            if (rem_dec == '0) begin
                                n_phase = PH_PREFIX;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

    assign o_req = req;

endmodule

FILE: hw/rtl/lpfr_emitter.sv
module lpfr_emitter import lpfr_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_cfg           i_cfg,
    input  t_req           i_req,
    output logic           o_res_free,
    lpfr_out_if.source     o_out
);

    // Result register.
    logic              r_valid;
    logic              r_hdr;
    logic [HIDX_W-1:0] r_idx;
    logic [BYTE_W-1:0] r_byte;
    logic [KIND_W-1:0] r_kind;
    logic              r_fend;

    // Header fields captured at launch.
    logic [WORD_W-1:0] r_len;
    logic [WORD_W-1:0] r_seq;
    logic [51:0]       r_pp_lo;
    logic [WORD_W-1:0] r_pp_hi;
    logic [TS_W-1:0]   r_ts;

    logic                     res_last;
    logic                     take;
    logic [HDR_BYTES*8-1:0]   hdr_vec;
    logic [BYTE_W-1:0]        hdr_byte;

    assign res_last   = !r_hdr || (r_idx == HDR_LAST_IDX);
    assign take       = r_valid && o_out.ready;
    assign o_res_free = !r_valid || (take && res_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (i_req.valid) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (take) begin
            if (res_last) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + HIDX_W'(1);
            end
        end
    end

    // Payload of the result register and header capture.
    always_ff @(posedge i_clk) begin
        if (i_req.valid) begin
            r_hdr  <= i_req.hdr;
            r_byte <= i_req.data;
            r_kind <= i_req.kind;
            r_fend <= i_req.fend;
            if (i_req.hdr) begin
                r_len   <= i_req.len;
                r_seq   <= i_req.seq;
                r_pp_lo <= 52'(i_req.ms[WORD_W-1:0]) * 52'(NS_PER_MS);
                r_pp_hi <= 32'(i_req.ms[MS_W-1:WORD_W]) * 32'(NS_PER_MS);
            end
        end
    end

    // Timestamp sum is registered from the registered partial products, long before its bytes go out.
    always_ff @(posedge i_clk) begin
        r_ts <= TS_W'(r_pp_lo) + {r_pp_hi, 32'd0};
    end

    assign hdr_vec = {HDR_MAGIC, i_cfg.version, i_cfg.codec, i_cfg.width, i_cfg.height,
                      r_ts, r_seq, r_len};
    assign hdr_byte = hdr_vec[{~r_idx, 3'b000} +: BYTE_W];

    assign o_out.valid     = r_valid;
    assign o_out.out_byte  = r_hdr ? hdr_byte : r_byte;
    assign o_out.kind      = r_hdr ? KIND_HEADER : r_kind;
    assign o_out.frame_end = r_hdr ? 1'b0 : r_fend;
    assign o_out.run_last  = res_last;

endmodule

FILE: hw/rtl/length_prefixed_frame_reframer.sv
// Channel  Dir  Handshake        Word contents
// i_in     in   valid / ready    cmd, in_byte, time_ms
// o_out    out  valid / ready    out_byte, kind, frame_end, run_last
// i_cfg    in   valid / ready    index, data (always ready)
//
// One input word is taken per cycle while the result slot is free, and results
// drain at one word per cycle while o_out is ready. A valid length prefix
// launches a 32-word header burst from the result register; input words wait
// in the input register until the burst's final word leaves.
// Reset is synchronous and restores all configuration registers and parser state.
// Either side may stall at any time without loss.
module length_prefixed_frame_reframer import lpfr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lpfr_in_if.sink     i_in,
    lpfr_out_if.source  o_out,
    lpfr_cfg_if.sink    i_cfg
);

    t_cfg cfg;
    t_req req;
    logic res_free;

    // Configuration registers.
    lpfr_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // Input register and length-prefix parser.
    lpfr_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_cfg      (cfg),
        .i_res_free (res_free),
        .o_req      (req)
    );

    // Result register and header serialiser.
    lpfr_emitter u_emitter (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_req      (req),
        .o_res_free (res_free),
        .o_out      (o_out)
    );

    // A header burst blocks new results until its final word leaves.
    a_hdr_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.kind == KIND_HEADER && !o_out.run_last) |-> !res_free)
        else $error("result slot freed in the middle of a header burst");

    // A header word that is taken and not last is followed by another header word.
    a_hdr_runs_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.kind == KIND_HEADER && !o_out.run_last)
        |=> (o_out.valid && o_out.kind == KIND_HEADER))
        else $error("header burst broken off");

    // The end of a frame is marked only on a payload word that closes its run.
    a_fend_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.frame_end) |-> (o_out.kind == KIND_PAYLOAD && o_out.run_last))
        else $error("frame end on a word that is not payload");

    // A new request only arrives when the result slot can take it.
    a_req_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req.valid |-> res_free)
        else $error("result request while the result register is busy");

endmodule
